@@ sv/khpr_pkg.sv @@
// Shared types, constants and codes for the key hash partition router.
// Used by every module of the block but khpr_ram; depends on nothing.
package khpr_pkg;

  localparam int CONNECTIONS_DEF = 16;

  localparam int HASH_W      = 64;
  localparam int PART_W      = 16;
  localparam int RR_W        = 32;
  localparam int BYTE_W      = 8;
  localparam int CONN_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DIV_CNT_W   = 7;

  // The FNV prime is 2^40 + 0x1b3.
  localparam logic [HASH_W-1:0] FNV_BASIS       = 64'hcbf29ce484222325;
  localparam logic [8:0]        FNV_PRIME_LOW   = 9'h1b3;
  localparam int                FNV_PRIME_SHIFT = 40;

  localparam logic [PART_W-1:0] RR_REQUEST = 16'hffff;

  localparam logic [DIV_CNT_W-1:0] HASH_ITERS = 7'd64;
  localparam logic [DIV_CNT_W-1:0] RR_ITERS   = 7'd32;
  localparam logic [DIV_CNT_W-1:0] LEAD_ITERS = 7'd16;

  localparam logic CMD_KEY_BYTE = 1'b0;
  localparam logic CMD_ROUTE    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_TOPIC   = 2'd1,
    STATUS_NO_PART    = 2'd2,
    STATUS_NOT_LEADER = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEADER_CHECK_ENABLE = 2'd0,
    CFG_BROKER_COUNT        = 2'd1,
    CFG_OWN_BROKER_ID       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_HASH,
    DIV_RR,
    DIV_LEAD
  } div_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_ROUTE,
    S_DIV_PART,
    S_LEADER,
    S_DIV_LEAD,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] key_byte;
    logic [CONN_W-1:0] connection;
    logic [PART_W-1:0] requested_partition;
    logic [PART_W-1:0] partition_count;
    logic              role_known;
    logic              is_leader;
    logic              partition_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PART_W-1:0] chosen_partition;
  } out_item_t;

  typedef struct packed {
    logic     accept;
    logic     hash_add;
    logic     key_clear;
    logic     clear_wr;
    logic     div_start;
    div_sel_t div_sel;
    logic     rr_write;
    logic     part_from_req;
    logic     part_from_rem;
    logic     set_status;
    status_t  status_code;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_command;
    logic count_zero;
    logic had_key;
    logic rr_req;
    logic req_oob;
    logic leader_en;
    logic role_known;
    logic is_leader;
    logic present;
    logic div_busy;
    logic rem_match;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/khpr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module khpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/khpr_div.sv @@
// Bit-serial restoring divider giving the remainder of a 64-bit dividend by a
// 16-bit divisor, one quotient bit per cycle. Depends on khpr_pkg.
module khpr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [khpr_pkg::HASH_W-1:0]     dividend,
  input  logic [khpr_pkg::PART_W-1:0]     divisor,
  input  logic [khpr_pkg::DIV_CNT_W-1:0]  iters,
  output logic                            busy,
  output logic [khpr_pkg::PART_W-1:0]     remainder
);

  logic [khpr_pkg::HASH_W-1:0]    quo_r;
  logic [khpr_pkg::PART_W-1:0]    rem_r;
  logic [khpr_pkg::PART_W-1:0]    rem_nxt;
  logic [khpr_pkg::PART_W:0]      trial;
  logic [khpr_pkg::DIV_CNT_W-1:0] cnt_r;

  always_comb begin
    trial = {rem_r, quo_r[khpr_pkg::HASH_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = khpr_pkg::PART_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[khpr_pkg::PART_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= iters;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[khpr_pkg::HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy      = (cnt_r != '0);
  assign remainder = rem_r;

endmodule

@@ sv/khpr_datapath.sv @@
// Datapath: key hash, configuration registers, round-robin counter memory,
// shared divider and result register. Depends on khpr_pkg, khpr_ram, khpr_div.
module khpr_datapath #(
  parameter int CONNECTIONS = khpr_pkg::CONNECTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  khpr_pkg::ctrl_cmd_t               cmd,
  output khpr_pkg::dp_status_t              status,
  input  khpr_pkg::in_item_t                in_data,
  input  logic                              cfg_wr,
  input  logic [khpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [khpr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output khpr_pkg::out_item_t               out_data
);

  localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam logic [AW-1:0] CLEAR_LAST = AW'(CONNECTIONS - 1);

  logic [khpr_pkg::HASH_W-1:0]    hash_r;
  logic [khpr_pkg::HASH_W-1:0]    mul_r;
  logic                           seen_r;
  khpr_pkg::in_item_t             req_r;
  logic [khpr_pkg::PART_W-1:0]    part_r;
  khpr_pkg::status_t              status_r;
  logic [AW-1:0]                  clr_r;
  logic                           leader_en_r;
  logic [khpr_pkg::PART_W-1:0]    brokers_r;
  logic [khpr_pkg::PART_W-1:0]    own_id_r;
  logic                           out_valid_r;
  khpr_pkg::out_item_t            out_r;

  logic [khpr_pkg::HASH_W-1:0]    key_x;
  logic [khpr_pkg::RR_W-1:0]      rr_rd;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [khpr_pkg::RR_W-1:0]      wr_data;
  logic [AW-1:0]                  rd_addr;
  logic [khpr_pkg::HASH_W-1:0]    div_dividend;
  logic [khpr_pkg::PART_W-1:0]    div_divisor;
  logic [khpr_pkg::DIV_CNT_W-1:0] div_iters;
  logic                           div_busy;
  logic [khpr_pkg::PART_W-1:0]    div_rem;
  logic [khpr_pkg::PART_W-1:0]    brokers_eff;

  function automatic logic [AW-1:0] conn_index(input logic [khpr_pkg::CONN_W-1:0] c);
    logic [AW-1:0] idx;
    idx = '0;
    for (int i = 0; i < (1 << khpr_pkg::CONN_W); i++) begin
      if (c == khpr_pkg::CONN_W'(i)) begin
        idx = AW'(i % CONNECTIONS);
      end
    end
    return idx;
  endfunction

  assign key_x = hash_r ^ {{(khpr_pkg::HASH_W - khpr_pkg::BYTE_W){1'b0}}, in_data.key_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= khpr_pkg::FNV_BASIS;
      seen_r <= 1'b0;
    end else if (cmd.key_clear) begin
      hash_r <= khpr_pkg::FNV_BASIS;
      seen_r <= 1'b0;
    end else if (cmd.accept && in_data.command == khpr_pkg::CMD_KEY_BYTE) begin
      hash_r <= key_x;
    end else if (cmd.hash_add) begin
      hash_r <= mul_r + (hash_r << khpr_pkg::FNV_PRIME_SHIFT);
      seen_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_data.command == khpr_pkg::CMD_KEY_BYTE) begin
        mul_r <= key_x * khpr_pkg::FNV_PRIME_LOW;
      end else begin
        req_r <= in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_en_r <= 1'b0;
      brokers_r   <= 16'd1;
      own_id_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        khpr_pkg::CFG_LEADER_CHECK_ENABLE: leader_en_r <= cfg_data[0];
        khpr_pkg::CFG_BROKER_COUNT:        brokers_r   <= cfg_data;
        khpr_pkg::CFG_OWN_BROKER_ID:       own_id_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  assign rd_addr = conn_index(in_data.connection);
  assign wr_en   = cmd.clear_wr | cmd.rr_write;
  assign wr_addr = cmd.clear_wr ? clr_r : conn_index(req_r.connection);
  assign wr_data = cmd.clear_wr ? '0 : rr_rd + 32'd1;

  khpr_ram #(
    .WIDTH (khpr_pkg::RR_W),
    .DEPTH (CONNECTIONS)
  ) u_rr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rr_rd)
  );

  assign brokers_eff = (brokers_r == '0) ? 16'd1 : brokers_r;

  always_comb begin
    case (cmd.div_sel)
      khpr_pkg::DIV_RR: begin
        div_dividend = {rr_rd, {(khpr_pkg::HASH_W - khpr_pkg::RR_W){1'b0}}};
        div_divisor  = req_r.partition_count;
        div_iters    = khpr_pkg::RR_ITERS;
      end
      khpr_pkg::DIV_LEAD: begin
        div_dividend = {part_r, {(khpr_pkg::HASH_W - khpr_pkg::PART_W){1'b0}}};
        div_divisor  = brokers_eff;
        div_iters    = khpr_pkg::LEAD_ITERS;
      end
      default: begin
        div_dividend = hash_r;
        div_divisor  = req_r.partition_count;
        div_iters    = khpr_pkg::HASH_ITERS;
      end
    endcase
  end

  khpr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.part_from_req) begin
      part_r <= req_r.requested_partition;
    end else if (cmd.part_from_rem) begin
      part_r <= div_rem;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status           <= status_r;
      out_r.chosen_partition <= (status_r == khpr_pkg::STATUS_OK) ? part_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    status.in_command = in_data.command;
    status.count_zero = (req_r.partition_count == '0);
    status.had_key    = seen_r;
    status.rr_req     = (req_r.requested_partition == khpr_pkg::RR_REQUEST);
    status.req_oob    = (req_r.requested_partition >= req_r.partition_count);
    status.leader_en  = leader_en_r;
    status.role_known = req_r.role_known;
    status.is_leader  = req_r.is_leader;
    status.present    = req_r.partition_present;
    status.div_busy   = div_busy;
    status.rem_match  = (div_rem == own_id_r);
    status.clear_last = (clr_r == CLEAR_LAST);
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

@@ sv/khpr_ctrl.sv @@
// Controller state machine sequencing hashing, partition selection, the
// leadership check and result hand-off. Depends on khpr_pkg.
module khpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  khpr_pkg::dp_status_t status,
  output khpr_pkg::ctrl_cmd_t  cmd
);

  khpr_pkg::ctrl_state_t state_r;
  khpr_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= khpr_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      khpr_pkg::S_CLEAR: begin
        if (status.clear_last) state_nxt = khpr_pkg::S_IDLE;
      end
      khpr_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (status.in_command == khpr_pkg::CMD_KEY_BYTE) ?
                      khpr_pkg::S_HASH : khpr_pkg::S_ROUTE;
        end
      end
      khpr_pkg::S_HASH: state_nxt = khpr_pkg::S_IDLE;
      khpr_pkg::S_ROUTE: begin
        if (status.count_zero) begin
          state_nxt = khpr_pkg::S_RESULT;
        end else if (status.had_key || status.rr_req) begin
          state_nxt = khpr_pkg::S_DIV_PART;
        end else if (status.req_oob) begin
          state_nxt = khpr_pkg::S_RESULT;
        end else begin
          state_nxt = khpr_pkg::S_LEADER;
        end
      end
      khpr_pkg::S_DIV_PART: begin
        if (!status.div_busy) state_nxt = khpr_pkg::S_LEADER;
      end
      khpr_pkg::S_LEADER: begin
        state_nxt = (status.leader_en && !status.role_known) ?
                    khpr_pkg::S_DIV_LEAD : khpr_pkg::S_RESULT;
      end
      khpr_pkg::S_DIV_LEAD: begin
        if (!status.div_busy) state_nxt = khpr_pkg::S_RESULT;
      end
      khpr_pkg::S_RESULT: begin
        if (status.out_free) state_nxt = khpr_pkg::S_IDLE;
      end
      default: state_nxt = khpr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = khpr_pkg::DIV_HASH;
    cmd.status_code = khpr_pkg::STATUS_OK;
    in_ready = (state_r == khpr_pkg::S_IDLE);
    case (state_r)
      khpr_pkg::S_CLEAR: cmd.clear_wr = 1'b1;
      khpr_pkg::S_IDLE: cmd.accept = in_valid;
      khpr_pkg::S_HASH: cmd.hash_add = 1'b1;
      khpr_pkg::S_ROUTE: begin
        cmd.key_clear = 1'b1;
        if (status.count_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = khpr_pkg::STATUS_NO_TOPIC;
        end else if (status.had_key) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = khpr_pkg::DIV_HASH;
        end else if (status.rr_req) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = khpr_pkg::DIV_RR;
          cmd.rr_write  = 1'b1;
        end else if (status.req_oob) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = khpr_pkg::STATUS_NO_PART;
        end else begin
          cmd.part_from_req = 1'b1;
        end
      end
      khpr_pkg::S_DIV_PART: cmd.part_from_rem = !status.div_busy;
      khpr_pkg::S_LEADER: begin
        if (status.leader_en && !status.role_known) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = khpr_pkg::DIV_LEAD;
        end else begin
          cmd.set_status = 1'b1;
          if (status.leader_en && !status.is_leader) begin
            cmd.status_code = khpr_pkg::STATUS_NOT_LEADER;
          end else if (!status.present) begin
            cmd.status_code = khpr_pkg::STATUS_NO_PART;
          end else begin
            cmd.status_code = khpr_pkg::STATUS_OK;
          end
        end
      end
      khpr_pkg::S_DIV_LEAD: begin
        cmd.div_sel    = khpr_pkg::DIV_LEAD;
        cmd.set_status = !status.div_busy;
        if (!status.rem_match) begin
          cmd.status_code = khpr_pkg::STATUS_NOT_LEADER;
        end else if (!status.present) begin
          cmd.status_code = khpr_pkg::STATUS_NO_PART;
        end else begin
          cmd.status_code = khpr_pkg::STATUS_OK;
        end
      end
      khpr_pkg::S_RESULT: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ sv/key_hash_partition_router.sv @@
// Key hash partition router: input, result and configuration channels.
// Transactions on the input channel carry either one key byte or a route
// request. Key bytes fold into a 64-bit FNV-1a hash; each is folded in by
// a narrow constant multiply, then the add of the shifted high term.
// A route request yields exactly one result transaction carrying a status
// and the chosen partition; key bytes yield none.
// Routes for an unknown topic, an out-of-range index, or an explicit
// partition with no fallback leadership check do not use the divider. The
// single bit-serial divider serves hash modulo partition count, the
// round-robin counter and the fallback partition-modulo-broker-count check.
// One item is worked on at a time; a finished result waits in the output
// register, and the next item is accepted while it is held.
// If the receiver stalls, a further route request completes its work and
// then waits until the output register frees.
// After reset the round-robin counter memory is cleared, one entry per
// cycle, until all CONNECTIONS entries are zero; no input is accepted
// meanwhile, while configuration writes are always accepted. Write
// configuration only when the block is idle.
module key_hash_partition_router #(
  parameter int CONNECTIONS = khpr_pkg::CONNECTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  khpr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output khpr_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [khpr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [khpr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  khpr_pkg::ctrl_cmd_t  ctrl_cmd;
  khpr_pkg::dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  khpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  khpr_datapath #(
    .CONNECTIONS (CONNECTIONS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_key_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == khpr_pkg::CMD_KEY_BYTE) |=> !in_ready)
    else $error("Input accepted during the hash update of a key byte.");

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dp_status.div_busy)
    else $error("Divider still busy while the block takes new input.");

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.div_start |-> !dp_status.div_busy)
    else $error("Divider started while a division is in progress.");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> dp_status.out_free)
    else $error("Result loaded over a transaction not yet taken.");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for key_hash_partition_router: directed and random key-byte
// and route-request transactions, with every result checked against a built-in predictor.
// Depends on khpr_pkg and the key_hash_partition_router RTL.
module testbench;

  localparam logic [khpr_pkg::HASH_W-1:0] KEY_HASH_PRIME = 64'h0000_0100_0000_01b3;
  localparam int N_CONN = 16;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  khpr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  khpr_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [khpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [khpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  khpr_pkg::in_item_t pending_items[$];
  khpr_pkg::out_item_t route_results_due[$];
  bit seen_error = 1'b0;

  logic leader_check_on = 1'b0;
  logic [15:0] broker_total = 16'd1;
  logic [15:0] own_id = 16'd0;
  logic [khpr_pkg::HASH_W-1:0] running_hash = khpr_pkg::FNV_BASIS;
  logic key_pending = 1'b0;
  logic [khpr_pkg::RR_W-1:0] rr_count [N_CONN];

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pattern = 16'hffff;
  int unsigned pattern_age = 0;
  khpr_pkg::out_item_t due;

  key_hash_partition_router #(
    .CONNECTIONS(N_CONN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void predict_route(khpr_pkg::in_item_t it);
    logic [khpr_pkg::HASH_W-1:0] hash_now;
    logic had_key;
    logic [khpr_pkg::PART_W-1:0] part;
    logic [khpr_pkg::PART_W-1:0] brokers;
    logic lead;
    khpr_pkg::status_t st;
    khpr_pkg::out_item_t res;
    if (it.command == khpr_pkg::CMD_KEY_BYTE) begin
      running_hash = (running_hash ^ {56'd0, it.key_byte}) * KEY_HASH_PRIME;
      key_pending = 1'b1;
      return;
    end
    hash_now = running_hash;
    had_key = key_pending;
    running_hash = khpr_pkg::FNV_BASIS;
    key_pending = 1'b0;
    st = khpr_pkg::STATUS_OK;
    part = '0;
    lead = 1'b1;
    if (it.partition_count == '0) begin
      st = khpr_pkg::STATUS_NO_TOPIC;
    end else if (had_key) begin
      part = khpr_pkg::PART_W'(hash_now % it.partition_count);
    end else if (it.requested_partition == khpr_pkg::RR_REQUEST) begin
      part = khpr_pkg::PART_W'(rr_count[it.connection] % it.partition_count);
      rr_count[it.connection] = rr_count[it.connection] + 1'b1;
    end else if (it.requested_partition >= it.partition_count) begin
      st = khpr_pkg::STATUS_NO_PART;
    end else begin
      part = it.requested_partition;
    end
    if (st == khpr_pkg::STATUS_OK && leader_check_on) begin
      if (it.role_known) begin
        lead = it.is_leader;
      end else begin
        brokers = (broker_total == '0) ? 16'd1 : broker_total;
        lead = ((part % brokers) == own_id);
      end
      if (!lead) st = khpr_pkg::STATUS_NOT_LEADER;
    end
    if (st == khpr_pkg::STATUS_OK && !it.partition_present) st = khpr_pkg::STATUS_NO_PART;
    res.status = st;
    res.chosen_partition = (st == khpr_pkg::STATUS_OK) ? part : '0;
    route_results_due.push_back(res);
  endfunction

  function automatic khpr_pkg::in_item_t key_item(logic [7:0] value);
    logic [63:0] raw;
    khpr_pkg::in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(khpr_pkg::in_item_t)-1:0];
    it.command = khpr_pkg::CMD_KEY_BYTE;
    it.key_byte = value;
    return it;
  endfunction

  function automatic khpr_pkg::in_item_t route_item(logic [3:0] conn, logic [15:0] req,
                                                    logic [15:0] count, logic known,
                                                    logic leader, logic present);
    khpr_pkg::in_item_t it;
    it.command = khpr_pkg::CMD_ROUTE;
    it.key_byte = 8'($urandom);
    it.connection = conn;
    it.requested_partition = req;
    it.partition_count = count;
    it.role_known = known;
    it.is_leader = leader;
    it.partition_present = present;
    return it;
  endfunction

  task automatic cfg_write(khpr_pkg::cfg_reg_t reg_sel, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= reg_sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (reg_sel)
      khpr_pkg::CFG_LEADER_CHECK_ENABLE: leader_check_on = value[0];
      khpr_pkg::CFG_BROKER_COUNT: broker_total = value;
      khpr_pkg::CFG_OWN_BROKER_ID: own_id = value;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic leader_en, logic [15:0] brokers, logic [15:0] own,
                           int unsigned n_random, bit with_directed);
    int unsigned queued;
    int unsigned pick;
    int unsigned n_keys;
    logic [63:0] raw;
    logic [15:0] count;
    logic [15:0] req;
    cfg_write(khpr_pkg::CFG_LEADER_CHECK_ENABLE, {15'd0, leader_en});
    cfg_write(khpr_pkg::CFG_BROKER_COUNT, brokers);
    cfg_write(khpr_pkg::CFG_OWN_BROKER_ID, own);
    if (with_directed) begin
      pending_items.push_back(key_item(8'h00));
      pending_items.push_back(key_item(8'hff));
      pending_items.push_back(route_item(4'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, khpr_pkg::RR_REQUEST, 16'd0,
                                         1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, 16'd3, 16'd5, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, 16'd5, 16'd5, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, 16'hfffe, 16'hffff, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, 16'd0, 16'd1, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, khpr_pkg::RR_REQUEST, 16'hffff,
                                         1'b1, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd0, khpr_pkg::RR_REQUEST, 16'hffff,
                                         1'b1, 1'b1, 1'b0));
      pending_items.push_back(route_item(4'd0, khpr_pkg::RR_REQUEST, 16'd3,
                                         1'b1, 1'b0, 1'b1));
      pending_items.push_back(route_item(4'd15, khpr_pkg::RR_REQUEST, 16'd7,
                                         1'b0, 1'b0, 1'b1));
      pending_items.push_back(route_item(4'd0, khpr_pkg::RR_REQUEST, 16'd7,
                                         1'b0, 1'b0, 1'b1));
      pending_items.push_back(route_item(4'd4, 16'd1, 16'd10, 1'b0, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd4, 16'd2, 16'd10, 1'b0, 1'b1, 1'b1));
      pending_items.push_back(route_item(4'd4, 16'd2, 16'd10, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(key_item(8'h61));
      pending_items.push_back(key_item(8'h62));
      pending_items.push_back(route_item(4'd9, khpr_pkg::RR_REQUEST, 16'hffff,
                                         1'b1, 1'b1, 1'b1));
      pending_items.push_back(key_item(8'h5a));
      pending_items.push_back(route_item(4'd9, 16'd100, 16'd1000, 1'b1, 1'b1, 1'b1));
    end
    queued = 0;
    while (queued < n_random) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        raw = {$urandom, $urandom};
        pending_items.push_back(raw[$bits(khpr_pkg::in_item_t)-1:0]);
        queued++;
      end else begin
        if (pick < 8) n_keys = 0;
        else if (pick == 8) n_keys = $urandom_range(13, 40);
        else n_keys = $urandom_range(1, 12);
        repeat (n_keys) pending_items.push_back(key_item(8'($urandom)));
        case ($urandom_range(0, 9))
          0: count = '0;
          1: count = 16'hffff;
          2, 3: count = 16'($urandom);
          default: count = 16'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 2))
          0: req = khpr_pkg::RR_REQUEST;
          1: req = (count == '0) ? 16'($urandom) : 16'($urandom_range(0, count - 1));
          default: req = 16'($urandom);
        endcase
        pending_items.push_back(route_item(4'($urandom), req, count, 1'($urandom),
                                           1'($urandom), $urandom_range(0, 7) != 0));
        queued += n_keys + 1;
      end
    end
    while (pending_items.size() != 0 || in_valid || route_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_route(in_data);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (route_results_due.size() == 0) begin
          $error("unexpected result transaction: status %0d, chosen_partition %0d",
                 out_data.status, out_data.chosen_partition);
          seen_error = 1'b1;
        end else begin
          due = route_results_due.pop_front();
          if (out_data.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_data.status);
            seen_error = 1'b1;
          end
          if (out_data.chosen_partition !== due.chosen_partition) begin
            $error("chosen_partition: expected %0d, got %0d", due.chosen_partition,
                   out_data.chosen_partition);
            seen_error = 1'b1;
          end
        end
      end
      out_ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hffff;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'h0001 << $urandom_range(0, 15);
        endcase
      end
    end
  end

  initial begin
    foreach (rr_count[i]) rr_count[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(1'b1, 16'd2, 16'd1, 150, 1'b1);
    run_phase(1'b0, 16'd1, 16'd0, 170, 1'b0);
    run_phase(1'b1, 16'd1, 16'd0, 150, 1'b0);
    run_phase(1'b1, 16'hffff, 16'hffff, 150, 1'b0);
    run_phase(1'b1, 16'd0, 16'd0, 120, 1'b0);
    run_phase(1'b1, 16'd3, 16'd2, 150, 1'b0);
    run_phase(1'b0, 16'd7, 16'd3, 100, 1'b0);
    if (!seen_error) begin
      $display("** key_hash_partition_router: PASSED **");
    end else begin
      $display("** key_hash_partition_router: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** key_hash_partition_router: FAILED **");
    $finish;
  end

endmodule
